// ===== sv/pam_pkg.sv =====
// Shared types and codes for the polynomial add / multiply block.
// No dependencies; imported by every module of the block.
`default_nettype none

package pam_pkg;

    localparam int COEF_W = 32;

    typedef logic [COEF_W-1:0] coef_t;

    // Request kinds
    localparam logic [2:0] KIND_LOAD_FIRST  = 3'd0;
    localparam logic [2:0] KIND_LOAD_SECOND = 3'd1;
    localparam logic [2:0] KIND_SUM         = 3'd2;
    localparam logic [2:0] KIND_PRODUCT     = 3'd3;
    localparam logic [2:0] KIND_CLEAR       = 3'd4;

    typedef struct packed {
        logic clear;
        logic fwd;
        logic bwd;
    } ring_ctrl_t;

    typedef struct packed {
        logic fill;
        logic drain;
    } acc_ctrl_t;

    typedef struct packed {
        logic issue;
        logic hi;
        logic clear;
    } mac_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/pam_ring_cell.sv =====
// One coefficient cell of a polynomial store ring.
// Depends on pam_pkg.
`default_nettype none

module pam_ring_cell
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pam_pkg::ring_ctrl_t ctrl,
    input  wire logic               load,
    input  wire pam_pkg::coef_t     addend,
    input  wire pam_pkg::coef_t     from_up,
    input  wire pam_pkg::coef_t     from_dn,
    output pam_pkg::coef_t          value
);
    import pam_pkg::*;

    coef_t value_reg;
    coef_t value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.clear)
        begin
            value_next = '0;
        end
        else if (load)
        begin
            value_next = value_reg + addend;
        end
        else if (ctrl.fwd)
        begin
            value_next = from_up;
        end
        else if (ctrl.bwd)
        begin
            value_next = from_dn;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

`default_nettype wire

// ===== sv/pam_acc_cell.sv =====
// One cell of the result chain: filled from above, drained upwards.
// Depends on pam_pkg.
`default_nettype none

module pam_acc_cell
(
    input  wire logic               clk,
    input  wire pam_pkg::acc_ctrl_t ctrl,
    input  wire pam_pkg::coef_t     fill_in,
    input  wire pam_pkg::coef_t     drain_in,
    output pam_pkg::coef_t          value
);
    import pam_pkg::*;

    coef_t value_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.fill)
        begin
            value_reg <= fill_in;
        end
        else if (ctrl.drain)
        begin
            value_reg <= drain_in;
        end
    end

    assign value = value_reg;

endmodule

`default_nettype wire

// ===== sv/pam_mac.sv =====
// Shared multiply-accumulate unit: registered product, low and high accumulators.
// Depends on pam_pkg.
`default_nettype none

module pam_mac
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pam_pkg::mac_ctrl_t ctrl,
    input  wire pam_pkg::coef_t    a,
    input  wire pam_pkg::coef_t    b,
    output pam_pkg::coef_t         acc_lo,
    output pam_pkg::coef_t         acc_hi
);
    import pam_pkg::*;

    coef_t prod_reg;
    logic  prod_hi_reg;
    logic  prod_valid_reg;
    coef_t acc_lo_reg;
    coef_t acc_lo_next;
    coef_t acc_hi_reg;
    coef_t acc_hi_next;
    coef_t add_lo;
    coef_t add_hi;

    always_comb
    begin
        add_lo = (prod_valid_reg && !prod_hi_reg) ? prod_reg : '0;
        add_hi = (prod_valid_reg && prod_hi_reg) ? prod_reg : '0;
        acc_lo_next = (ctrl.clear ? '0 : acc_lo_reg) + add_lo;
        acc_hi_next = (ctrl.clear ? '0 : acc_hi_reg) + add_hi;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= ctrl.issue;
        end
    end

    // low 32 bits only: wraps as 32-bit integer arithmetic
    always_ff @(posedge clk)
    begin
        prod_reg    <= a * b;
        prod_hi_reg <= ctrl.hi;
        acc_lo_reg  <= acc_lo_next;
        acc_hi_reg  <= acc_hi_next;
    end

    assign acc_lo = acc_lo_reg;
    assign acc_hi = acc_hi_reg;

endmodule

`default_nettype wire

// ===== sv/polynomial_add_multiply.sv =====
// Top level of the polynomial add / multiply block.
// Depends on pam_pkg, pam_ring_cell, pam_acc_cell and pam_mac.
//
// Two rings of MAX_DEGREE+1 coefficient cells hold the stores. A sum streams
// both rings through an adder. A product walks the rings against each other
// through a single shared multiply-accumulate unit, one residue class of
// exponents at a time. Results then drain from a chain of 2*(MAX_DEGREE+1)
// cells, one exponent per cycle while the output is not stalled. Input is
// taken only while no sum or product is in progress; the output register lets
// the next request in while the final term still waits to be taken.
`default_nettype none

module polynomial_add_multiply #(
    parameter int MAX_DEGREE = 15
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         kind,
    input  wire logic signed [15:0] coefficient,
    input  wire logic [3:0]         exponent,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      coefficient_res,
    output logic [4:0]              exponent_res,
    output logic                    last,
    output logic                    empty_res
);
    import pam_pkg::*;

    localparam int N  = MAX_DEGREE + 1;
    localparam int NQ = 2 * N;
    localparam int IW = (N > 1) ? $clog2(N) : 1;
    localparam int EW = $clog2(NQ);
    localparam int CW = $clog2(N + 1);
    localparam logic [IW-1:0] TOP_IDX  = IW'(MAX_DEGREE);
    localparam logic [CW-1:0] CYC_LAST = CW'(N);
    localparam logic [EW-1:0] Q_TOP    = EW'(NQ - 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SUM   = 5'b00010,
        ST_PROD  = 5'b00100,
        ST_FLUSH = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cyc_reg, cyc_next;
    logic [IW-1:0]   s_reg, s_next;
    logic [IW-1:0]   ha_reg, ha_next;
    logic [IW-1:0]   hb_reg, hb_next;
    logic [IW-1:0]   fill_idx_reg, fill_idx_next;
    logic            lo_found_reg, lo_found_next;
    logic            hi_found_reg, hi_found_next;
    logic [IW-1:0]   lo_idx_reg, lo_idx_next;
    logic [IW-1:0]   hi_idx_reg, hi_idx_next;
    logic [EW-1:0]   e_reg, e_next;

    logic            out_valid_reg, out_valid_next;
    coef_t           out_coef_reg, out_coef_next;
    logic [4:0]      out_exp_reg, out_exp_next;
    logic            out_last_reg, out_last_next;
    logic            out_empty_reg, out_empty_next;
    logic            out_load;

    ring_ctrl_t      ring_a_ctrl;
    ring_ctrl_t      ring_b_ctrl;
    acc_ctrl_t       acc_ctrl;
    mac_ctrl_t       mac_ctrl;

    coef_t           a_val [N];
    coef_t           b_val [N];
    coef_t           q_val [NQ];
    logic [N-1:0]    exp_hit;
    coef_t           addend;
    coef_t           acc_lo;
    coef_t           acc_hi;
    coef_t           lo_val;
    coef_t           hi_val;
    coef_t           q_head;

    logic            in_fire;
    logic            load_first;
    logic            load_second;
    logic            push;
    logic            is_hi;
    logic            any_found;
    logic [EW-1:0]   lowest_e;
    logic            at_lowest;
    logic            can_load;

    assign in_ready    = (state_reg == ST_IDLE);
    assign in_fire     = in_valid && in_ready;
    assign load_first  = in_fire && (kind == KIND_LOAD_FIRST);
    assign load_second = in_fire && (kind == KIND_LOAD_SECOND);
    assign addend      = {{(COEF_W - 16){coefficient[15]}}, coefficient};

    assign is_hi     = ({1'b0, ha_reg} + {1'b0, hb_reg}) > {1'b0, TOP_IDX};
    assign q_head    = q_val[NQ-1];
    assign any_found = lo_found_reg || hi_found_reg;
    assign lowest_e  = lo_found_reg ? EW'(lo_idx_reg) : (EW'(hi_idx_reg) + EW'(N));
    assign at_lowest = (e_reg == lowest_e);
    assign can_load  = !out_valid_reg || out_ready;

    assign lo_val = (state_reg == ST_SUM) ? (a_val[0] + b_val[0]) : acc_lo;
    assign hi_val = (state_reg == ST_SUM) ? '0 : acc_hi;

    // Store rings
    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_ring
            assign exp_hit[k] = ({28'd0, exponent} == 32'(k));

            pam_ring_cell u_cell_a (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ring_a_ctrl),
                .load    (load_first && exp_hit[k]),
                .addend  (addend),
                .from_up (a_val[(k + 1) % N]),
                .from_dn (a_val[(k + N - 1) % N]),
                .value   (a_val[k])
            );

            pam_ring_cell u_cell_b (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ring_b_ctrl),
                .load    (load_second && exp_hit[k]),
                .addend  (addend),
                .from_up (b_val[(k + 1) % N]),
                .from_dn (b_val[(k + N - 1) % N]),
                .value   (b_val[k])
            );
        end
    endgenerate

    // Result chain: cell k holds exponent k after filling
    generate
        for (k = 0; k < NQ; k++)
        begin : g_chain
            coef_t fill_in;
            coef_t drain_in;

            if (k == NQ - 1)
            begin : g_top
                assign fill_in = hi_val;
            end
            else if (k == N - 1)
            begin : g_mid
                assign fill_in = lo_val;
            end
            else
            begin : g_inner
                assign fill_in = q_val[k + 1];
            end

            if (k == 0)
            begin : g_bottom
                assign drain_in = '0;
            end
            else
            begin : g_upper
                assign drain_in = q_val[k - 1];
            end

            pam_acc_cell u_cell_q (
                .clk      (clk),
                .ctrl     (acc_ctrl),
                .fill_in  (fill_in),
                .drain_in (drain_in),
                .value    (q_val[k])
            );
        end
    endgenerate

    pam_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .a      (a_val[0]),
        .b      (b_val[0]),
        .acc_lo (acc_lo),
        .acc_hi (acc_hi)
    );

    always_comb
    begin
        state_next     = state_reg;
        cyc_next       = cyc_reg;
        s_next         = s_reg;
        ha_next        = ha_reg;
        hb_next        = hb_reg;
        fill_idx_next  = fill_idx_reg;
        lo_found_next  = lo_found_reg;
        hi_found_next  = hi_found_reg;
        lo_idx_next    = lo_idx_reg;
        hi_idx_next    = hi_idx_reg;
        e_next         = e_reg;
        ring_a_ctrl    = '0;
        ring_b_ctrl    = '0;
        acc_ctrl       = '0;
        mac_ctrl       = '0;
        push           = 1'b0;
        out_load       = 1'b0;
        out_coef_next  = out_coef_reg;
        out_exp_next   = out_exp_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (kind)
                        KIND_SUM:
                        begin
                            state_next    = ST_SUM;
                            fill_idx_next = '0;
                            lo_found_next = 1'b0;
                            hi_found_next = 1'b0;
                        end
                        KIND_PRODUCT:
                        begin
                            state_next    = ST_PROD;
                            cyc_next      = '0;
                            s_next        = '0;
                            ha_next       = '0;
                            hb_next       = '0;
                            fill_idx_next = '0;
                            lo_found_next = 1'b0;
                            hi_found_next = 1'b0;
                        end
                        KIND_CLEAR:
                        begin
                            ring_a_ctrl.clear = 1'b1;
                            ring_b_ctrl.clear = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SUM:
            begin
                push            = 1'b1;
                ring_a_ctrl.fwd = 1'b1;
                ring_b_ctrl.fwd = 1'b1;
                if (fill_idx_reg == TOP_IDX)
                begin
                    state_next = ST_EMIT;
                    e_next     = Q_TOP;
                end
            end

            // Heads move in opposite directions, so each pass pairs every term whose
            // exponents sum to one residue class; at the end of a pass only ring A
            // moves, which steps the class on by one.
            ST_PROD:
            begin
                ring_a_ctrl.fwd = 1'b1;
                ha_next         = (ha_reg == TOP_IDX) ? '0 : IW'(ha_reg + 1'b1);
                mac_ctrl.clear  = (cyc_reg == '0);
                push            = (cyc_reg == '0) && (s_reg != '0);
                if (cyc_reg != CYC_LAST)
                begin
                    ring_b_ctrl.bwd = 1'b1;
                    mac_ctrl.issue  = 1'b1;
                    mac_ctrl.hi     = is_hi;
                    hb_next         = (hb_reg == '0) ? TOP_IDX : IW'(hb_reg - 1'b1);
                    cyc_next        = CW'(cyc_reg + 1'b1);
                end
                else
                begin
                    cyc_next = '0;
                    if (s_reg == TOP_IDX)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        s_next = IW'(s_reg + 1'b1);
                    end
                end
            end

            ST_FLUSH:
            begin
                push       = 1'b1;
                state_next = ST_EMIT;
                e_next     = Q_TOP;
            end

            ST_EMIT:
            begin
                if (!any_found)
                begin
                    if (can_load)
                    begin
                        out_load       = 1'b1;
                        out_coef_next  = '0;
                        out_exp_next   = '0;
                        out_last_next  = 1'b1;
                        out_empty_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else if (q_head != '0)
                begin
                    if (can_load)
                    begin
                        out_load       = 1'b1;
                        out_coef_next  = q_head;
                        out_exp_next   = 5'(e_reg);
                        out_last_next  = at_lowest;
                        out_empty_next = 1'b0;
                        acc_ctrl.drain = 1'b1;
                        e_next         = EW'(e_reg - 1'b1);
                        if (at_lowest)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                else
                begin
                    acc_ctrl.drain = 1'b1;
                    e_next         = EW'(e_reg - 1'b1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Terms arrive in ascending exponent order; the first nonzero is lowest
        if (push)
        begin
            acc_ctrl.fill = 1'b1;
            fill_idx_next = IW'(fill_idx_reg + 1'b1);
            if (!lo_found_reg && (lo_val != '0))
            begin
                lo_found_next = 1'b1;
                lo_idx_next   = fill_idx_reg;
            end
            if (!hi_found_reg && (hi_val != '0))
            begin
                hi_found_next = 1'b1;
                hi_idx_next   = fill_idx_reg;
            end
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cyc_reg       <= '0;
            s_reg         <= '0;
            ha_reg        <= '0;
            hb_reg        <= '0;
            fill_idx_reg  <= '0;
            lo_found_reg  <= 1'b0;
            hi_found_reg  <= 1'b0;
            e_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cyc_reg       <= cyc_next;
            s_reg         <= s_next;
            ha_reg        <= ha_next;
            hb_reg        <= hb_next;
            fill_idx_reg  <= fill_idx_next;
            lo_found_reg  <= lo_found_next;
            hi_found_reg  <= hi_found_next;
            e_reg         <= e_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_idx_reg    <= lo_idx_next;
        hi_idx_reg    <= hi_idx_next;
        out_coef_reg  <= out_coef_next;
        out_exp_reg   <= out_exp_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
    end

    assign out_valid       = out_valid_reg;
    assign coefficient_res = out_coef_reg;
    assign exponent_res    = out_exp_reg;
    assign last            = out_last_reg;
    assign empty_res       = out_empty_reg;

endmodule

`default_nettype wire

// ===== sv/pam_checker.sv =====
// Port-level checks for polynomial_add_multiply, bound to the top level.
// Depends on pam_pkg and polynomial_add_multiply.
`default_nettype none

module pam_checker
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic [2:0]        kind,
    input wire logic signed [15:0] coefficient,
    input wire logic [3:0]        exponent,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic signed [31:0] coefficient_res,
    input wire logic [4:0]        exponent_res,
    input wire logic              last,
    input wire logic              empty_res
);
    import pam_pkg::*;

    // An offered request holds until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(kind)
            && $stable(coefficient) && $stable(exponent))
        else $error("request changed while waiting");

    // A stalled result transfer keeps its item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(coefficient_res)
            && $stable(exponent_res) && $stable(last) && $stable(empty_res))
        else $error("result changed while stalled");

    // Zero result is a single, final, all-zero item
    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_res |-> last && (coefficient_res == '0) && (exponent_res == '0))
        else $error("malformed empty result");

    // Zero terms are never emitted
    a_nonzero_term: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !empty_res |-> coefficient_res != '0)
        else $error("zero coefficient emitted");

    // A sum or product request holds off the next input
    a_busy_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && ((kind == KIND_SUM) || (kind == KIND_PRODUCT)) |=> !in_ready)
        else $error("input taken during a result run");

endmodule

bind polynomial_add_multiply pam_checker u_pam_checker (.*);

`default_nettype wire
